/* rtl/sfdf_pkg.sv */
package sfdf_pkg;

	// Payload store geometry.
	localparam int PAYLOAD_WORDS = 64;
	localparam int WORD_AW = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1;

	// Field values that mark acknowledge and data frames.
	localparam logic [7:0] ACK_FIELD_LEN = 8'h04;
	localparam logic [7:0] ACK_DESC      = 8'hF1;
	localparam logic [7:0] DATA_DESC     = 8'h80;

	// Configuration registers.
	localparam int          CFG_AW         = 3;
	localparam logic        REG_SYNC_FIRST  = 1'b0;
	localparam logic        REG_SYNC_SECOND = 1'b1;
	localparam logic [7:0]  SYNC_FIRST_RST  = 8'd117;
	localparam logic [7:0]  SYNC_SECOND_RST = 8'd101;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_DESC,
		PH_LEN,
		PH_PAYLOAD,
		PH_CHK1,
		PH_CHK2
	} phase_t;

	typedef enum logic [1:0] {
		EM_IDLE,
		EM_READ,
		EM_LOAD,
		EM_SHOW
	} em_state_t;

	// Summary of a finished frame, handed from the parser to the emitter.
	typedef struct packed {
		logic               good;
		logic [7:0]         desc;
		logic [7:0]         len;
		logic [WORD_AW-1:0] last_idx;
		logic               is_ack;
		logic               is_data;
		logic [7:0]         echo;
		logic [7:0]         code;
	} frame_info_t;

	// One write into the payload store.
	typedef struct packed {
		logic               en;
		logic [WORD_AW-1:0] addr;
		logic [31:0]        data;
	} store_wr_t;

endpackage

/* rtl/sync_frame_deframer_fletcher.sv */
// Sync-framed byte deframer with a Fletcher-style check.
// Input channel: one received byte (rx_byte) per beat on in_valid/in_stall.
// The parser hunts for the two sync bytes, then takes descriptor, length,
// payload and two check bytes; payload words go into a 64-word store.
// Output channel: one beat per 32-bit payload word of a good frame (first
// byte most significant, last word zero padded, at least one beat), or a
// single beat with status 1 when the check fails. last marks the final beat.
// Flow: a byte that does not end a frame is taken without a stall. After the
// second check byte the input stalls while the store is read back: each word
// passes through read, load and present steps, and the present step lasts as
// long as the receiver holds out_stall; an error beat skips read and load.
// While out_stall is high the current beat holds and in_stall stays high.
// Reset clears the parser to hunting and the emitter to idle, and sets the
// sync registers to 117 and 101. Registers sit on the APB-style port at
// byte addresses 0 and 4; a write lands at once, so write them only while
// the block is idle.
module sync_frame_deframer_fletcher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [sfdf_pkg::CFG_AW-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        status,
	output logic [7:0]  descriptor,
	output logic [7:0]  payload_length,
	output logic [5:0]  word_index,
	output logic [31:0] payload_word,
	output logic        last,
	output logic        is_ack,
	output logic        is_data,
	output logic [7:0]  ack_echo,
	output logic [7:0]  reply_code
);
	import sfdf_pkg::*;

	logic               sel_first;
	logic [7:0]         sync_first_val_q;
	logic [7:0]         sync_second_val_q;
	logic               cfg_wr;
	logic               byte_en;
	logic               busy;
	logic               frame_done;
	frame_info_t        frame_info;
	store_wr_t          wr;
	logic               rd_en;
	logic [WORD_AW-1:0] rd_addr;
	logic [31:0]        rd_data;

	// Register port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign sel_first = (paddr[2] == REG_SYNC_FIRST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_val_q  <= SYNC_FIRST_RST;
			sync_second_val_q <= SYNC_SECOND_RST;
		end else if (cfg_wr) begin
			if (sel_first) begin
				sync_first_val_q <= pwdata[7:0];
			end else begin
				sync_second_val_q <= pwdata[7:0];
			end
		end
	end

	always_comb begin
		case (paddr[2])
			REG_SYNC_FIRST:  prdata = {24'd0, sync_first_val_q};
			REG_SYNC_SECOND: prdata = {24'd0, sync_second_val_q};
			default:         prdata = 32'd0;
		endcase
	end

	// Input is held off while a frame is being emitted.
	assign in_stall = busy;
	assign byte_en  = in_valid && !in_stall;

	sfdf_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_en     (byte_en),
		.rx_byte     (rx_byte),
		.sync_first  (sync_first_val_q),
		.sync_second (sync_second_val_q),
		.wr          (wr),
		.frame_done  (frame_done),
		.frame_info  (frame_info)
	);

	sfdf_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	sfdf_emitter u_emitter (
		.clk            (clk),
		.arst_n         (arst_n),
		.frame_done     (frame_done),
		.frame_info     (frame_info),
		.busy           (busy),
		.rd_en          (rd_en),
		.rd_addr        (rd_addr),
		.rd_data        (rd_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.descriptor     (descriptor),
		.payload_length (payload_length),
		.word_index     (word_index),
		.payload_word   (payload_word),
		.last           (last),
		.is_ack         (is_ack),
		.is_data        (is_data),
		.ack_echo       (ack_echo),
		.reply_code     (reply_code)
	);

endmodule

/* rtl/sfdf_store.sv */
module sfdf_store (
	input  logic                       clk,
	input  sfdf_pkg::store_wr_t        wr,
	input  logic                       rd_en,
	input  logic [sfdf_pkg::WORD_AW-1:0] rd_addr,
	output logic [31:0]                rd_data
);
	import sfdf_pkg::*;

	logic [31:0] mem [PAYLOAD_WORDS];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/sfdf_parser.sv */
module sfdf_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_en,
	input  logic [7:0]            rx_byte,
	input  logic [7:0]            sync_first,
	input  logic [7:0]            sync_second,
	output sfdf_pkg::store_wr_t   wr,
	output logic                  frame_done,
	output sfdf_pkg::frame_info_t frame_info
);
	import sfdf_pkg::*;

	phase_t      phase_q, phase_d;
	logic        prev_sync_q;
	logic [7:0]  desc_q;
	logic [7:0]  len_q;
	logic [7:0]  cnt_q;
	logic [7:0]  sum_lo_q;
	logic [7:0]  sum_hi_q;
	logic [7:0]  chk1_q;
	logic [31:0] word_q;
	logic [31:0] first_q;

	logic [7:0]  add_lo;
	logic [7:0]  add_hi;
	logic [7:0]  sync_lo;
	logic [7:0]  sync_hi;
	logic [8:0]  cnt_inc;
	logic        payload_end;
	logic [31:0] word_d;
	logic [6:0]  nwords;
	logic        good;

	// Running sums: low accumulates bytes, high accumulates low.
	assign add_lo  = sum_lo_q + rx_byte;
	assign add_hi  = sum_hi_q + add_lo;
	assign sync_lo = sync_first + sync_second;
	assign sync_hi = sync_first + sync_lo;

	assign cnt_inc     = {1'b0, cnt_q} + 9'd1;
	assign payload_end = cnt_inc >= {1'b0, len_q};

	// Merge the byte into the current big-endian word; a new word starts zeroed.
	always_comb begin
		case (cnt_q[1:0])
			2'd0:    word_d = {rx_byte, 24'd0};
			2'd1:    word_d = word_q | {8'd0, rx_byte, 16'd0};
			2'd2:    word_d = word_q | {16'd0, rx_byte, 8'd0};
			default: word_d = word_q | {24'd0, rx_byte};
		endcase
	end

	// Complete words and the final partial word go to the store.
	always_comb begin
		wr.en   = byte_en && (phase_q == PH_PAYLOAD) && ((cnt_q[1:0] == 2'd3) || payload_end)
			&& (32'(cnt_q[7:2]) < PAYLOAD_WORDS);
		wr.addr = WORD_AW'(cnt_q[7:2]);
		wr.data = word_d;
	end

	// Phase sequencing.
	always_comb begin
		phase_d = phase_q;
		if (byte_en) begin
			case (phase_q)
				PH_HUNT: begin
					if (prev_sync_q && (rx_byte == sync_second)) begin
						phase_d = PH_DESC;
					end
				end
				PH_DESC:    phase_d = PH_LEN;
				PH_LEN:     phase_d = (rx_byte == 8'd0) ? PH_CHK1 : PH_PAYLOAD;
				PH_PAYLOAD: phase_d = payload_end ? PH_CHK1 : PH_PAYLOAD;
				PH_CHK1:    phase_d = PH_CHK2;
				PH_CHK2:    phase_d = PH_HUNT;
				default:    phase_d = PH_HUNT;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
		end else begin
			phase_q <= phase_d;
		end
	end

	// Frame registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_sync_q <= 1'b0;
			desc_q      <= 8'd0;
			len_q       <= 8'd0;
			cnt_q       <= 8'd0;
			sum_lo_q    <= 8'd0;
			sum_hi_q    <= 8'd0;
			chk1_q      <= 8'd0;
			word_q      <= 32'd0;
			first_q     <= 32'd0;
		end else if (byte_en) begin
			case (phase_q)
				PH_HUNT: begin
					if (prev_sync_q && (rx_byte == sync_second)) begin
						prev_sync_q <= 1'b0;
						sum_lo_q    <= sync_lo;
						sum_hi_q    <= sync_hi;
						cnt_q       <= 8'd0;
					end else begin
						prev_sync_q <= (rx_byte == sync_first);
					end
				end
				PH_DESC: begin
					desc_q   <= rx_byte;
					sum_lo_q <= add_lo;
					sum_hi_q <= add_hi;
				end
				PH_LEN: begin
					len_q    <= rx_byte;
					sum_lo_q <= add_lo;
					sum_hi_q <= add_hi;
					cnt_q    <= 8'd0;
					word_q   <= 32'd0;
					first_q  <= 32'd0;
				end
				PH_PAYLOAD: begin
					sum_lo_q <= add_lo;
					sum_hi_q <= add_hi;
					cnt_q    <= cnt_inc[7:0];
					word_q   <= word_d;
					if (cnt_q[7:2] == 6'd0) begin
						first_q <= word_d;
					end
				end
				PH_CHK1: begin
					chk1_q <= rx_byte;
				end
				PH_CHK2: begin
					prev_sync_q <= 1'b0;
				end
				default: begin
					prev_sync_q <= 1'b0;
				end
			endcase
		end
	end

	// Frame summary, valid with the second check byte.
	assign good   = (chk1_q == sum_lo_q) && (rx_byte == sum_hi_q);
	assign nwords = 7'(({1'b0, len_q} + 9'd3) >> 2);

	always_comb begin
		frame_done      = byte_en && (phase_q == PH_CHK2);
		frame_info.good = good;
		frame_info.desc = desc_q;
		frame_info.len  = len_q;
		if (len_q == 8'd0) begin
			frame_info.last_idx = '0;
		end else if (32'(nwords) > PAYLOAD_WORDS) begin
			frame_info.last_idx = WORD_AW'(PAYLOAD_WORDS - 1);
		end else begin
			frame_info.last_idx = WORD_AW'(nwords - 7'd1);
		end
		frame_info.is_ack  = good && (first_q[31:24] == ACK_FIELD_LEN)
			&& (first_q[23:16] == ACK_DESC);
		frame_info.is_data = good && (desc_q == DATA_DESC);
		frame_info.echo    = good ? first_q[15:8] : 8'd0;
		frame_info.code    = good ? first_q[7:0] : 8'd0;
	end

`ifndef SYNTHESIS
	// A payload phase only follows a nonzero length byte.
	a_payload_len: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (len_q != 8'd0))
		else $error("payload phase with zero length");
`endif

endmodule

/* rtl/sfdf_emitter.sv */
module sfdf_emitter (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         frame_done,
	input  sfdf_pkg::frame_info_t        frame_info,
	output logic                         busy,
	output logic                         rd_en,
	output logic [sfdf_pkg::WORD_AW-1:0] rd_addr,
	input  logic [31:0]                  rd_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         status,
	output logic [7:0]                   descriptor,
	output logic [7:0]                   payload_length,
	output logic [5:0]                   word_index,
	output logic [31:0]                  payload_word,
	output logic                         last,
	output logic                         is_ack,
	output logic                         is_data,
	output logic [7:0]                   ack_echo,
	output logic [7:0]                   reply_code
);
	import sfdf_pkg::*;

	em_state_t          state_q, state_d;
	frame_info_t        info_q;
	logic [WORD_AW-1:0] idx_q;
	logic [31:0]        word_q;
	logic               at_last;

	assign at_last = (idx_q == info_q.last_idx);

	// Next state and store read control.
	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = idx_q;
		case (state_q)
			EM_IDLE: begin
				if (frame_done) begin
					state_d = frame_info.good ? EM_READ : EM_SHOW;
				end
			end
			EM_READ: begin
				rd_en   = 1'b1;
				state_d = EM_LOAD;
			end
			EM_LOAD: begin
				state_d = EM_SHOW;
			end
			EM_SHOW: begin
				if (!out_stall) begin
					state_d = (at_last || !info_q.good) ? EM_IDLE : EM_READ;
				end
			end
			default: state_d = EM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Frame summary, word counter and output word.
	always_ff @(posedge clk) begin
		case (state_q)
			EM_IDLE: begin
				if (frame_done) begin
					info_q <= frame_info;
					idx_q  <= '0;
					word_q <= 32'd0;
				end
			end
			EM_LOAD: begin
				word_q <= (info_q.len == 8'd0) ? 32'd0 : rd_data;
			end
			EM_SHOW: begin
				if (!out_stall) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			default: begin
				word_q <= word_q;
			end
		endcase
	end

	assign busy           = (state_q != EM_IDLE);
	assign out_valid      = (state_q == EM_SHOW);
	assign status         = !info_q.good;
	assign descriptor     = info_q.desc;
	assign payload_length = info_q.len;
	assign word_index     = 6'(idx_q);
	assign payload_word   = word_q;
	assign last           = at_last || !info_q.good;
	assign is_ack         = info_q.is_ack;
	assign is_data        = info_q.is_data;
	assign ack_echo       = info_q.echo;
	assign reply_code     = info_q.code;

`ifndef SYNTHESIS
	// A new frame only arrives while the emitter is idle.
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		frame_done |-> (state_q == EM_IDLE))
		else $error("frame finished while emitter busy");

	// An error beat is always the final beat of its frame.
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> last)
		else $error("error beat without last");

	// The word counter never runs past the frame's last word.
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (idx_q <= info_q.last_idx))
		else $error("word index past last word");
`endif

endmodule
